/* hdl/indexed_color_clut_expand_core_macros.svh */
// Assertion macros shared by the palette lookup RTL
`ifndef INDEXED_COLOR_CLUT_EXPAND_CORE_MACROS_SVH
`define INDEXED_COLOR_CLUT_EXPAND_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ICCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ICCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/icce_pkg.sv */
// Types, codes and helpers for the indexed color palette lookup
package icce_pkg;

    // request kinds
    localparam logic REQ_PALETTE_WRITE = 1'b0;
    localparam logic REQ_PIXEL         = 1'b1;

    // pixel modes
    localparam logic MODE_8BPP = 1'b0;
    localparam logic MODE_4BPP = 1'b1;

    // register word index (byte address bit 2)
    localparam logic REG_PIXEL_MODE = 1'b0;
    localparam logic REG_SWIZZLE    = 1'b1;

    // lookup stage control, travels with the RAM read data
    typedef struct packed {
        logic mode_4bpp;
        logic hit_lo;     // first lookup index present in the table
        logic hit_hi;     // second lookup index present in the table
    } t_lkp_ctrl;

    // swap address bits 3 and 4 (block-interleaved table order)
    function automatic logic [7:0] f_swizzle(input logic [7:0] addr);
        f_swizzle = {addr[7:5], addr[3], addr[4], addr[2:0]};
    endfunction

    // 0..128 alpha to 0..255: zero stays zero, else 2a-1, saturated
    function automatic logic [7:0] f_scale_alpha(input logic [7:0] a);
        logic [7:0] s;
        priority if (a == 8'd0) begin
            s = 8'd0;
        end else if (a[7]) begin
            s = 8'hFF;
        end else begin
            s = {a[6:0], 1'b0} - 8'd1;
        end
        f_scale_alpha = s;
    endfunction

endpackage

/* hdl/icce_ram.sv */
// Generic RAM: one write port, two registered read ports
module icce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/indexed_color_clut_expand_core.sv */
// Indexed color palette lookup: 8 bpp / 4 bpp index bytes to RGBA colors
//
// Input channel (i_in_valid / o_in_stall) carries either a palette write
// (req_type 0: color stored at palette_index, bits 3 and 4 swapped when
// swizzling is on) or a pixel byte (req_type 1). A palette write gives no
// result. A pixel byte gives one color in 8 bpp mode, or two colors in
// 4 bpp mode, low nibble first; o_last marks the final color of a byte.
// Output channel is o_out_valid / i_out_stall, backed by an output register.
// Throughput is set by the single output register: one byte per cycle in
// 8 bpp mode while the receiver does not stall; in 4 bpp mode a new byte
// is taken only as the second color of the previous one is loaded. Palette
// writes go at one per cycle unless a pending lookup stalls the input. The
// table RAM has two read ports so both nibbles are looked up in one access.
// Reset: all table entries read as zero (per-entry valid flops, cleared at
// once, no clearing pass), pixel mode 8 bpp, swizzling on. When the
// receiver stalls, the output holds and the input stalls as soon as the
// lookup stage is full. Configuration over APB, registers at 0x0 and 0x4.
module indexed_color_clut_expand_core
    import icce_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_palette_index,
    input  logic [31:0] i_palette_color,
    input  logic [7:0]  i_pixel_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_rgba,
    output logic        o_last
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] NUM_ENTRIES = 9'(PALETTE_ENTRIES);

    logic                        r_pixel_mode;
    logic                        r_swizzle_en;
    logic [PALETTE_ENTRIES-1:0]  r_ent_vld;
    logic                        r_lkp_vld;
    logic                        n_lkp_vld;
    logic                        r_lkp_phase;
    logic                        n_lkp_phase;
    t_lkp_ctrl                   r_lkp;
    logic                        r_out_vld;
    logic                        n_out_vld;
    logic [31:0]                 r_rgba;
    logic                        r_last;

    logic        cfg_wr;
    logic        in_acc;
    logic        pix_acc;
    logic        pal_we;
    logic [7:0]  wr_addr8;
    logic        wr_in_range;
    logic [7:0]  lo_idx8;
    logic [7:0]  hi_idx8;
    logic        lo_in_range;
    logic        hi_in_range;
    logic [31:0] ram_lo;
    logic [31:0] ram_hi;
    logic        out_free;
    logic        lkp_load;
    logic        lkp_pop;
    logic [31:0] sel_color;
    logic        sel_hit;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= MODE_8BPP;
            r_swizzle_en <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PIXEL_MODE: r_pixel_mode <= pwdata[0];
                REG_SWIZZLE:    r_swizzle_en <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_PIXEL_MODE: prdata[0] = r_pixel_mode;
            REG_SWIZZLE:    prdata[0] = r_swizzle_en;
            default:        prdata = '0;
        endcase
    end

    // handshake and stage flow
    assign out_free   = !r_out_vld || !i_out_stall;
    assign lkp_load   = r_lkp_vld && out_free;
    assign lkp_pop    = lkp_load && (!r_lkp.mode_4bpp || r_lkp_phase);
    assign o_in_stall = r_lkp_vld && !lkp_pop;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pix_acc    = in_acc && (i_req_type == REQ_PIXEL);

    // palette write address
    assign wr_addr8    = r_swizzle_en ? f_swizzle(i_palette_index) : i_palette_index;
    assign wr_in_range = {1'b0, wr_addr8} < NUM_ENTRIES;
    assign pal_we      = in_acc && (i_req_type == REQ_PALETTE_WRITE) && wr_in_range;

    // lookup addresses
    assign lo_idx8     = (r_pixel_mode == MODE_4BPP) ? {4'd0, i_pixel_byte[3:0]}
                                                     : i_pixel_byte;
    assign hi_idx8     = {4'd0, i_pixel_byte[7:4]};
    assign lo_in_range = {1'b0, lo_idx8} < NUM_ENTRIES;
    assign hi_in_range = {1'b0, hi_idx8} < NUM_ENTRIES;

    // per-entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (pal_we) begin
            r_ent_vld[wr_addr8[AW-1:0]] <= 1'b1;
        end
    end

    icce_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (pal_we),
        .i_waddr   (wr_addr8[AW-1:0]),
        .i_wdata   (i_palette_color),
        .i_re      (pix_acc),
        .i_raddr_a (lo_idx8[AW-1:0]),
        .i_raddr_b (hi_idx8[AW-1:0]),
        .o_rdata_a (ram_lo),
        .o_rdata_b (ram_hi)
    );

    // lookup stage control
    always_comb begin
        n_lkp_vld = r_lkp_vld;
        if (pix_acc) begin
            n_lkp_vld = 1'b1;
        end else if (lkp_pop) begin
            n_lkp_vld = 1'b0;
        end
    end

    always_comb begin
        n_lkp_phase = r_lkp_phase;
        if (pix_acc || lkp_pop) begin
            n_lkp_phase = 1'b0;
        end else if (lkp_load) begin
            n_lkp_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lkp_vld   <= 1'b0;
            r_lkp_phase <= 1'b0;
        end else begin
            r_lkp_vld   <= n_lkp_vld;
            r_lkp_phase <= n_lkp_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_lkp.mode_4bpp <= (r_pixel_mode == MODE_4BPP);
            r_lkp.hit_lo    <= lo_in_range && r_ent_vld[lo_idx8[AW-1:0]];
            r_lkp.hit_hi    <= hi_in_range && r_ent_vld[hi_idx8[AW-1:0]];
        end
    end

    // color select and alpha rescale
    assign sel_color = r_lkp_phase ? ram_hi : ram_lo;
    assign sel_hit   = r_lkp_phase ? r_lkp.hit_hi : r_lkp.hit_lo;

    // output register
    always_comb begin
        n_out_vld = r_out_vld;
        if (lkp_load) begin
            n_out_vld = 1'b1;
        end else if (out_free) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lkp_load) begin
            if (sel_hit) begin
                r_rgba <= {f_scale_alpha(sel_color[31:24]), sel_color[23:0]};
            end else begin
                r_rgba <= '0;
            end
            r_last <= !r_lkp.mode_4bpp || r_lkp_phase;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rgba      = r_rgba;
    assign o_last      = r_last;

    `include "indexed_color_clut_expand_core_macros.svh"

    // second nibble only ever pending for a full 4 bpp lookup
    `ICCE_ASSERT_NOW(a_phase_mode, r_lkp_phase, r_lkp_vld && r_lkp.mode_4bpp, "phase without 4bpp item")
    // input stalls only behind a pending lookup
    `ICCE_ASSERT_NOW(a_stall_cause, o_in_stall, r_lkp_vld, "input stall with empty lookup stage")
    // first color of a 4 bpp byte is always followed by the second
    `ICCE_ASSERT_NEXT(a_pair_follows, o_out_valid && !i_out_stall && !o_last, o_out_valid && o_last, "second nibble color missing")
    // accepted pixel byte reaches the lookup stage
    `ICCE_ASSERT_NEXT(a_pix_lands, pix_acc, r_lkp_vld && !r_lkp_phase, "pixel byte lost")

endmodule

/* tb/tb_indexed_color_clut_expand_core.sv */
// Self-checking testbench for the indexed color palette lookup core
module tb_indexed_color_clut_expand_core;
    import icce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLUT_DEPTH    = 256;
    localparam int SETTLE_CYCLES = 4;   // lookup latency plus margin
    localparam int LONG_HOLD     = 80;  // long output stall, fills the pipe
    localparam int PHASE_ITEMS   = 180;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one directed step: a register write or an input transaction
    typedef struct packed {
        t_row_kind   kind;
        logic        reg_sel;   // config rows
        logic        reg_val;
        logic        req;       // item rows
        logic [7:0]  index;
        logic [31:0] color;
        logic [7:0]  pix;
        logic        typed;     // expected colors given in want_lo / want_hi
        logic [31:0] want_lo;
        logic [31:0] want_hi;
    } t_plan_row;

    typedef struct {
        logic [31:0] rgba;
        logic        last;
    } t_color;

    localparam int DIRECTED_ROWS = 25;
    localparam t_plan_row DIRECTED_PLAN [DIRECTED_ROWS] = '{
        // table is all zero after reset, 8 bpp, swizzle on
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h00,
          1'b1, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'hAA, 32'h5A5A5A5A, 8'hFF,
          1'b1, 32'h0, 32'h0},
        // swizzled write: 0x08 lands at 0x10, alpha 128 saturates
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h08, 32'h80123456, 8'hA5,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'hFF, 32'hFFFFFFFF, 8'h10,
          1'b1, 32'hFF123456, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h08,
          1'b1, 32'h0, 32'h0},
        // alpha 1 stays 1
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h00, 32'h01ABCDEF, 8'hFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h00,
          1'b1, 32'h01ABCDEF, 32'h0},
        // top entry, alpha far above 128
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'hFF, 32'hFFFFFFFF, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'hFF,
          1'b1, 32'hFFFFFFFF, 32'h0},
        // both swap bits set: address unchanged, alpha 64 -> 127
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h18, 32'h4000FF00, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h18,
          1'b1, 32'h7F00FF00, 32'h0},
        // 0x10 lands at 0x08, alpha zero stays zero
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h10, 32'h00C0FFEE, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h08,
          1'b1, 32'h00C0FFEE, 32'h0},
        // straight addressing, 4 bpp
        '{ROW_CFG, REG_SWIZZLE, 1'b0, REQ_PALETTE_WRITE, 8'h00, 32'h0, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_PIXEL_MODE, MODE_4BPP, REQ_PALETTE_WRITE, 8'h00, 32'h0, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h08, 32'h81000001, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h0F, 32'h7F0000AA, 8'h00,
          1'b0, 32'h0, 32'h0},
        // low nibble first, then high nibble
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'hF8,
          1'b1, 32'hFF000001, 32'hFD0000AA},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'hFF, 32'hFFFFFFFF, 8'h00,
          1'b1, 32'h01ABCDEF, 32'h01ABCDEF},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h0F,
          1'b1, 32'hFD0000AA, 32'h01ABCDEF},
        '{ROW_CFG, REG_SWIZZLE, 1'b1, REQ_PALETTE_WRITE, 8'h00, 32'h0, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PALETTE_WRITE, 8'h01, 32'h02112233, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h1F,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_PIXEL_MODE, MODE_8BPP, REQ_PALETTE_WRITE, 8'h00, 32'h0, 8'h00,
          1'b0, 32'h0, 32'h0},
        '{ROW_ITEM, REG_PIXEL_MODE, 1'b0, REQ_PIXEL, 8'h00, 32'h0, 8'h01,
          1'b0, 32'h0, 32'h0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = REQ_PALETTE_WRITE;
    logic [7:0]  i_palette_index = '0;
    logic [31:0] i_palette_color = '0;
    logic [7:0]  i_pixel_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_rgba;
    logic        o_last;

    // mirror of the block state
    logic [31:0] clut_mirror [CLUT_DEPTH];
    logic        mode_mirror;
    logic        swz_mirror;

    t_color      color_due [$];
    int          fault_count = 0;
    bit          hold_request = 1'b0;

    indexed_color_clut_expand_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_pixel_byte    (i_pixel_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rgba          (o_rgba),
        .o_last          (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void log_fault(string what, logic [31:0] want, logic [31:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
        end
    endfunction

    // table read with alpha rescale: 0 stays 0, else 2a-1 capped at 255
    function automatic logic [31:0] expand_color(input logic [7:0] idx);
        logic [31:0] entry;
        int unsigned alpha;
        if (int'(idx) >= CLUT_DEPTH) return 32'h0;
        entry = clut_mirror[idx];
        alpha = 32'(entry[31:24]);
        if (alpha != 0) alpha = 2 * alpha - 1;
        if (alpha > 255) alpha = 255;
        return {alpha[7:0], entry[23:0]};
    endfunction

    // update the mirror for one accepted transaction and queue its colors
    function automatic void predict_colors(input logic req, input logic [7:0] index,
                                           input logic [31:0] color, input logic [7:0] pix);
        logic [7:0] slot;
        if (req == REQ_PALETTE_WRITE) begin
            slot = index;
            if (swz_mirror) begin
                slot[3] = index[4];
                slot[4] = index[3];
            end
            if (int'(slot) < CLUT_DEPTH) clut_mirror[slot] = color;
        end else if (mode_mirror == MODE_8BPP) begin
            color_due.push_back('{expand_color(pix), 1'b1});
        end else begin
            color_due.push_back('{expand_color({4'h0, pix[3:0]}), 1'b0});
            color_due.push_back('{expand_color({4'h0, pix[7:4]}), 1'b1});
        end
    endfunction

    // idle cycles before a transaction: mostly none, a few long
    function automatic int next_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // offer one transaction, hold it until taken, then predict
    task automatic send_item(input logic req, input logic [7:0] index,
                             input logic [31:0] color, input logic [7:0] pix,
                             input logic typed, input logic [31:0] want_lo,
                             input logic [31:0] want_hi);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_palette_index <= index;
        i_palette_color <= color;
        i_pixel_byte    <= pix;
        do @(posedge i_clk); while (o_in_stall);
        if (typed && req == REQ_PIXEL) begin
            if (mode_mirror == MODE_8BPP) begin
                color_due.push_back('{want_lo, 1'b1});
            end else begin
                color_due.push_back('{want_lo, 1'b0});
                color_due.push_back('{want_hi, 1'b1});
            end
        end else begin
            predict_colors(req, index, color, pix);
        end
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic sel, input logic val);
        i_in_valid <= 1'b0;
        while (color_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {31'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_PIXEL_MODE) mode_mirror = val;
        else swz_mirror = val;
    endtask

    // one random phase under a fixed register setting
    task automatic run_phase(input logic mode, input logic swz, input int hold_at);
        logic [7:0]  index;
        logic [7:0]  alpha;
        logic [31:0] color;
        write_reg(REG_PIXEL_MODE, mode);
        write_reg(REG_SWIZZLE, swz);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == hold_at) hold_request = 1'b1;
            case ($urandom_range(0, 9))
                0: alpha = 8'h00;
                1: alpha = 8'h01;
                2: alpha = 8'h80;
                3: alpha = 8'($urandom_range(129, 255));
                default: alpha = 8'($urandom_range(0, 128));
            endcase
            color = {alpha, 24'($urandom())};
            // bias writes toward the low entries that 4 bpp can reach
            index = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 35) begin
                send_item(REQ_PALETTE_WRITE, index, color, 8'($urandom()),
                          1'b0, 32'h0, 32'h0);
            end else begin
                send_item(REQ_PIXEL, index, color, 8'($urandom()), 1'b0, 32'h0, 32'h0);
            end
        end
    endtask

    // output stall pattern, with a long hold on request
    initial begin : out_stall_gen
        int run;
        int pick;
        @(posedge i_clk);
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                run = LONG_HOLD;
            end else if (pick < 55) begin
                i_out_stall <= 1'b0;
                run = $urandom_range(1, 30);
            end else if (pick < 90) begin
                i_out_stall <= 1'b1;
                run = $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                run = $urandom_range(8, 30);
            end
            repeat (run) @(posedge i_clk);
        end
    end

    // check each accepted color against the oldest expectation
    always @(posedge i_clk) begin : color_check
        t_color due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (color_due.size() == 0) begin
                log_fault("unexpected color", 32'hx, o_rgba);
            end else begin
                due = color_due.pop_front();
                if (o_rgba !== due.rgba) log_fault("rgba", due.rgba, o_rgba);
                if (o_last !== due.last) log_fault("last", {31'h0, due.last}, {31'h0, o_last});
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_plan_row row;
        foreach (clut_mirror[i]) clut_mirror[i] = 32'h0;
        mode_mirror = MODE_8BPP;
        swz_mirror  = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED_PLAN[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                send_item(row.req, row.index, row.color, row.pix,
                          row.typed, row.want_lo, row.want_hi);
            end
        end

        run_phase(MODE_8BPP, 1'b0, -1);
        run_phase(MODE_4BPP, 1'b1, 60);
        run_phase(MODE_4BPP, 1'b0, 100);
        run_phase(MODE_8BPP, 1'b1, 40);

        i_in_valid <= 1'b0;
        while (color_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/icce_pkg.sv
hdl/icce_ram.sv
hdl/indexed_color_clut_expand_core.sv
tb/tb_indexed_color_clut_expand_core.sv
